// ===== rtl/core/falling_glyph_rain_engine_macros.svh =====
`ifndef FALLING_GLYPH_RAIN_ENGINE_MACROS_SVH
`define FALLING_GLYPH_RAIN_ENGINE_MACROS_SVH

// same-cycle implication
`define FGRE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("falling glyph rain engine check failed");

// next-cycle implication
`define FGRE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("falling glyph rain engine check failed");

`endif

// ===== rtl/core/fgre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fgre_pkg;

  localparam int GLYPH_W   = 7;
  localparam int GLOW_W    = 8;
  localparam int WORD_W    = 32;
  localparam int ACTION_W  = 2;
  localparam int MODE_W    = 2;
  localparam int SPEED_W   = 3;
  localparam int TIMER_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int PICKS     = 5;

  localparam int COLUMNS_RST = 80;
  localparam int ROWS_RST    = 60;

  localparam logic [GLOW_W-1:0] GLOW_STICKY = 8'd255;
  localparam logic [GLOW_W-1:0] GLOW_BRIGHT = 8'd254;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UPDATE = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DROP  = 2'd1,
    MODE_HOLD  = 2'd2,
    MODE_SLIDE = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [SPEED_W-1:0]   speed;
    logic [TIMER_W-1:0]   timer;
  } blip_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/falling_glyph_rain_engine.sv =====
// read: S_RD, then S_OUT; update: a per-row read-modify-write fade of the glow
// memory, S_BLIP, then S_FALL for a fall or a per-row glyph copy and S_FILL for
// a slide, then S_OUT; one request in flight at a time. reset and a clear
// request sweep the grid memory, 2^(clog2 MAX_ROWS + clog2 MAX_COLUMNS) entries
// (8192 at defaults), one entry a cycle, with input stalled.
`timescale 1ns / 1ps
`default_nettype none
module falling_glyph_rain_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int GLYPH_COUNT = 80,
  localparam int COL_W   = $clog2(MAX_COLUMNS),
  localparam int ROW_W   = $clog2(MAX_ROWS),
  localparam int CNT_C_W = $clog2(MAX_COLUMNS + 1),
  localparam int CNT_R_W = $clog2(MAX_ROWS + 1),
  localparam int CFG_W   = (CNT_C_W > CNT_R_W) ? CNT_C_W : CNT_R_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fgre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fgre_pkg::ACTION_W-1:0]     action,
  input  wire logic [COL_W-1:0]                  column,
  input  wire logic [ROW_W-1:0]                  row,
  input  wire logic [fgre_pkg::WORD_W-1:0]       rand_word,
  input  wire logic [fgre_pkg::GLYPH_W-1:0]      rand_glyph_a,
  input  wire logic [fgre_pkg::GLYPH_W-1:0]      rand_glyph_b,
  input  wire logic [fgre_pkg::GLYPH_W-1:0]      rand_glyph_c,
  input  wire logic [fgre_pkg::GLYPH_W-1:0]      rand_glyph_d,
  input  wire logic [fgre_pkg::GLYPH_W-1:0]      rand_glyph_e,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [fgre_pkg::GLYPH_W-1:0]      glyph_out,
  output logic      [fgre_pkg::GLOW_W-1:0]       glow_out,
  output logic      [fgre_pkg::MODE_W-1:0]       blip_mode_out
);
  import fgre_pkg::*;

  localparam int CC_W  = COL_W + 1;
  localparam int RC_W  = ROW_W + 1;
  localparam int GA_W  = ROW_W + COL_W;
  localparam int BW    = $bits(blip_ctl_t) + ROW_W;
  localparam int GTAB  = 2 ** GLYPH_W;
  localparam logic [GLYPH_W-1:0] GLYPH_RST = GLYPH_W'(GLYPH_COUNT - 1);

  typedef enum logic [10:0] {
    S_INIT     = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_RD       = 11'b000_0000_0100,
    S_FADE     = 11'b000_0000_1000,
    S_FADE_END = 11'b000_0001_0000,
    S_BLIP     = 11'b000_0010_0000,
    S_FALL     = 11'b000_0100_0000,
    S_COPY     = 11'b000_1000_0000,
    S_COPY_END = 11'b001_0000_0000,
    S_FILL     = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic   clr_item;
  logic [GA_W-1:0] sweep;

  logic [CNT_C_W-1:0] cols_cfg;
  logic [CNT_R_W-1:0] rows_cfg;
  logic [CC_W-1:0]    cols_eff;
  logic [RC_W-1:0]    rows_eff;

  logic [COL_W-1:0]   col_r;
  logic [WORD_W-1:0]  word_r;
  logic [GLYPH_W-1:0] gly_r [PICKS];
  logic               ok_r;

  logic [RC_W-1:0]    y_cnt;
  logic [RC_W-1:0]    frow;
  logic [SPEED_W-1:0] fi;
  logic [SPEED_W-1:0] fk;
  logic [SPEED_W-1:0] sp_r;
  logic               pos_r;
  logic [RC_W-1:0]    fill_start;
  logic               pend_fade;
  logic               pend_copy;
  logic [ROW_W-1:0]   pend_row;

  logic [GLYPH_W-1:0] res_glyph;
  logic [GLOW_W-1:0]  res_glow;
  logic [MODE_W-1:0]  res_mode;

  logic [GLYPH_W-1:0] mod_tab [GTAB];

  logic               glyph_we, glow_we, blip_we;
  logic [GA_W-1:0]    glyph_waddr, glow_waddr, glyph_raddr, glow_raddr;
  logic [GLYPH_W-1:0] glyph_wdata, glyph_rd;
  logic [GLOW_W-1:0]  glow_wdata, glow_rd;
  logic [COL_W-1:0]   blip_waddr, blip_raddr;
  logic [BW-1:0]      blip_wdata, blip_rd;

  blip_ctl_t          cur_ctl, nxt_ctl;
  logic [ROW_W-1:0]   cur_row, nxt_row;

  logic               accept;
  logic [11:0]        fade_p;
  logic [27:0]        fade_q;
  logic [GLOW_W-1:0]  fade_v;
  logic [2:0]         pick_ix;
  logic [GLYPH_W-1:0] pick;
  logic [ROW_W-1:0]   copy_src;
  logic               fill_go;
  logic               fall_wr;
  logic               stop_wr;

  for (genvar g = 0; g < GTAB; g++) begin : g_mod
    assign mod_tab[g] = GLYPH_W'(g % GLYPH_COUNT);
  end

  always_comb begin
    if (cols_cfg == '0) begin
      cols_eff = CC_W'(1);
    end else if (CC_W'(cols_cfg) > CC_W'(MAX_COLUMNS)) begin
      cols_eff = CC_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CC_W'(cols_cfg);
    end
    if (rows_cfg == '0) begin
      rows_eff = RC_W'(1);
    end else if (RC_W'(rows_cfg) > RC_W'(MAX_ROWS)) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = RC_W'(rows_cfg);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign cur_ctl = blip_ctl_t'(blip_rd[BW-1:ROW_W]);
  assign cur_row = blip_rd[ROW_W-1:0];

  fgre_blip_calc #(.ROW_W(ROW_W)) u_calc (
    .cur_ctl  (cur_ctl),
    .cur_row  (cur_row),
    .fall_row (frow),
    .rows     (rows_eff),
    .word     (word_r),
    .nxt_ctl  (nxt_ctl),
    .nxt_row  (nxt_row)
  );

  // glow darkening, floor(v * 9 / 10) by reciprocal
  assign fade_p = {1'b0, glow_rd, 3'b000} + 12'(glow_rd);
  assign fade_q = 28'(fade_p) * 28'd52429;
  assign fade_v = (glow_rd == GLOW_STICKY) ? GLOW_STICKY : fade_q[26:19];

  assign pick_ix  = (fk > 3'd4) ? 3'd4 : fk;
  assign pick     = gly_r[pick_ix];
  assign copy_src = ROW_W'(y_cnt - RC_W'(sp_r));
  assign fill_go  = (fk < sp_r) && (RC_W'(fk) <= fill_start);
  assign fall_wr  = (state == S_FALL) && (fi != '0) && (frow < rows_eff);
  assign stop_wr  = (state == S_BLIP) && (cur_ctl.mode == MODE_HOLD) &&
                    (RC_W'(cur_row) < rows_eff);

  always_comb begin
    glyph_raddr = {copy_src, col_r};
    glow_raddr  = {y_cnt[ROW_W-1:0], col_r};
    blip_raddr  = col_r;
    if (state == S_IDLE) begin
      glyph_raddr = {row, column};
      glow_raddr  = {row, column};
      blip_raddr  = column;
    end
  end

  always_comb begin
    glow_we     = 1'b0;
    glow_waddr  = {pend_row, col_r};
    glow_wdata  = fade_v;
    glyph_we    = 1'b0;
    glyph_waddr = {pend_row, col_r};
    glyph_wdata = glyph_rd;
    blip_we     = 1'b0;
    blip_waddr  = col_r;
    blip_wdata  = {nxt_ctl, nxt_row};
    if (state == S_INIT) begin
      glow_we     = 1'b1;
      glow_waddr  = sweep;
      glow_wdata  = '0;
      glyph_we    = 1'b1;
      glyph_waddr = sweep;
      glyph_wdata = GLYPH_RST;
      blip_we     = 1'b1;
      blip_waddr  = sweep[COL_W-1:0];
      blip_wdata  = '0;
    end else begin
      if (pend_fade) begin
        glow_we = 1'b1;
      end
      if (pend_copy) begin
        glyph_we = 1'b1;
      end
      if (fall_wr) begin
        glow_we     = 1'b1;
        glow_waddr  = {frow[ROW_W-1:0], col_r};
        glow_wdata  = pos_r ? GLOW_STICKY :
                      GLOW_BRIGHT - GLOW_W'({fi, 3'b000}) - GLOW_W'({fi, 1'b0});
        glyph_we    = 1'b1;
        glyph_waddr = {frow[ROW_W-1:0], col_r};
        glyph_wdata = pick;
      end
      if (stop_wr) begin
        glow_we     = 1'b1;
        glow_waddr  = {cur_row, col_r};
        glow_wdata  = GLOW_BRIGHT;
        glyph_we    = 1'b1;
        glyph_waddr = {cur_row, col_r};
        glyph_wdata = gly_r[0];
      end
      if (state == S_FILL && fill_go) begin
        glyph_we    = 1'b1;
        glyph_waddr = {ROW_W'(fill_start - RC_W'(fk)), col_r};
        glyph_wdata = pick;
      end
      if (state == S_BLIP && cur_ctl.mode != MODE_DROP) begin
        blip_we = 1'b1;
      end
      if (state == S_FALL && fi == '0) begin
        blip_we = 1'b1;
      end
    end
  end

  fgre_ram #(.WIDTH(GLYPH_W), .DEPTH(2 ** GA_W)) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (glyph_waddr),
    .wdata (glyph_wdata),
    .raddr (glyph_raddr),
    .rdata (glyph_rd)
  );

  fgre_ram #(.WIDTH(GLOW_W), .DEPTH(2 ** GA_W)) u_glow_ram (
    .clk   (clk),
    .we    (glow_we),
    .waddr (glow_waddr),
    .wdata (glow_wdata),
    .raddr (glow_raddr),
    .rdata (glow_rd)
  );

  fgre_ram #(.WIDTH(BW), .DEPTH(2 ** COL_W)) u_blip_ram (
    .clk   (clk),
    .we    (blip_we),
    .waddr (blip_waddr),
    .wdata (blip_wdata),
    .raddr (blip_raddr),
    .rdata (blip_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= CNT_C_W'(COLUMNS_RST);
      rows_cfg <= CNT_R_W'(ROWS_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_COLUMNS: cols_cfg <= CNT_C_W'(cfg_data);
        REG_ROWS:    rows_cfg <= CNT_R_W'(cfg_data);
        default:     cols_cfg <= cols_cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_item  <= 1'b0;
      sweep     <= '0;
      pend_fade <= 1'b0;
      pend_copy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend_fade <= (state == S_FADE);
      pend_copy <= (state == S_COPY);
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            state    <= clr_item ? S_OUT : S_IDLE;
            clr_item <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            col_r     <= column;
            word_r    <= rand_word;
            gly_r[0]  <= mod_tab[rand_glyph_a];
            gly_r[1]  <= mod_tab[rand_glyph_b];
            gly_r[2]  <= mod_tab[rand_glyph_c];
            gly_r[3]  <= mod_tab[rand_glyph_d];
            gly_r[4]  <= mod_tab[rand_glyph_e];
            y_cnt     <= '0;
            res_glyph <= '0;
            res_glow  <= '0;
            res_mode  <= '0;
            ok_r      <= (CC_W'(column) < cols_eff) && (RC_W'(row) < rows_eff);
            case (action)
              ACT_UPDATE: state <= (CC_W'(column) < cols_eff) ? S_FADE : S_OUT;
              ACT_READ: state <= S_RD;
              ACT_CLEAR: begin
                state    <= S_INIT;
                clr_item <= 1'b1;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          if (ok_r) begin
            res_glyph <= glyph_rd;
            res_glow  <= glow_rd;
            res_mode  <= cur_ctl.mode;
          end
          state <= S_OUT;
        end
        S_FADE: begin
          pend_row  <= y_cnt[ROW_W-1:0];
          if (y_cnt == rows_eff - 1'b1) begin
            state <= S_FADE_END;
          end else begin
            y_cnt <= y_cnt + 1'b1;
          end
        end
        S_FADE_END: begin
          state <= S_BLIP;
        end
        S_BLIP: begin
          sp_r  <= cur_ctl.speed;
          pos_r <= (cur_ctl.timer != '0) && !cur_ctl.timer[TIMER_W-1];
          fk    <= '0;
          unique case (cur_ctl.mode)
            MODE_DROP: begin
              frow  <= RC_W'(cur_row);
              fi    <= cur_ctl.speed;
              state <= S_FALL;
            end
            MODE_SLIDE: begin
              res_mode <= nxt_ctl.mode;
              if (rows_eff > RC_W'(cur_ctl.speed)) begin
                fill_start <= RC_W'(cur_ctl.speed) - 1'b1;
                y_cnt      <= rows_eff - 1'b1;
                state      <= S_COPY;
              end else begin
                fill_start <= rows_eff - 1'b1;
                state      <= S_FILL;
              end
            end
            default: begin
              res_mode <= nxt_ctl.mode;
              state    <= S_OUT;
            end
          endcase
        end
        S_FALL: begin
          if (fi == '0) begin
            res_mode <= nxt_ctl.mode;
            state    <= S_OUT;
          end else begin
            frow <= frow + 1'b1;
            fk   <= fk + 1'b1;
            if (frow + 1'b1 >= rows_eff) begin
              fi <= '0;
            end else begin
              fi <= fi - 1'b1;
            end
          end
        end
        S_COPY: begin
          pend_row  <= y_cnt[ROW_W-1:0];
          if (y_cnt == RC_W'(sp_r)) begin
            state <= S_COPY_END;
          end else begin
            y_cnt <= y_cnt - 1'b1;
          end
        end
        S_COPY_END: begin
          state <= S_FILL;
        end
        S_FILL: begin
          if (fill_go) begin
            fk <= fk + 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            glyph_out     <= res_glyph;
            glow_out      <= res_glow;
            blip_mode_out <= res_mode;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fgre_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fgre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/fgre_blip_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fgre_blip_calc #(
  parameter int ROW_W = 6,
  localparam int RC_W = ROW_W + 1
) (
  input  wire fgre_pkg::blip_ctl_t             cur_ctl,
  input  wire logic [ROW_W-1:0]                cur_row,
  input  wire logic [RC_W-1:0]                 fall_row,
  input  wire logic [RC_W-1:0]                 rows,
  input  wire logic [fgre_pkg::WORD_W-1:0]     word,
  output fgre_pkg::blip_ctl_t                  nxt_ctl,
  output logic      [ROW_W-1:0]                nxt_row
);
  import fgre_pkg::*;

  logic               pos;
  logic [TIMER_W-1:0] dec;
  logic [TIMER_W-1:0] t;

  assign pos = (cur_ctl.timer != '0) && !cur_ctl.timer[TIMER_W-1];
  assign dec = cur_ctl.timer - 1'b1;

  always_comb begin
    nxt_ctl = cur_ctl;
    nxt_row = cur_row;
    t       = cur_ctl.timer;
    unique case (cur_ctl.mode)
      MODE_IDLE: begin
        if (word[7:4] == 4'hf) begin
          nxt_ctl.mode  = MODE_DROP;
          nxt_ctl.speed = SPEED_W'(word[31:30]) + 1'b1;
          nxt_ctl.timer = '0;
          nxt_row       = '0;
        end else if (word[15:12] == 4'hf) begin
          nxt_ctl.mode  = MODE_SLIDE;
          nxt_ctl.timer = TIMER_W'(word[31:28]) + 8'd15;
          nxt_ctl.speed = SPEED_W'(word[25:24]) + 3'd2;
        end
      end
      MODE_DROP: begin
        if (pos) begin
          t = dec;
        end
        nxt_row = fall_row[ROW_W-1:0];
        if (fall_row >= rows) begin
          nxt_ctl.mode = MODE_IDLE;
          nxt_row      = '0;
        end
        if (t == '0) begin
          if (word[13:8] == 6'h3f) begin
            t = TIMER_W'(word[31:28]) + 8'd8;
          end else if (cur_ctl.speed > 3'd1 && word[6:0] == 7'h7f) begin
            nxt_ctl.mode = MODE_HOLD;
            t = TIMER_W'(word[31:26]) + 8'd30;
          end
        end
        nxt_ctl.timer = t;
      end
      MODE_HOLD: begin
        nxt_ctl.timer = dec;
        if (dec[TIMER_W-1]) begin
          nxt_ctl.mode = MODE_DROP;
        end
      end
      MODE_SLIDE: begin
        nxt_ctl.timer = dec;
        if (dec[TIMER_W-1]) begin
          nxt_ctl.mode = MODE_IDLE;
        end
      end
      default: begin
        nxt_ctl = cur_ctl;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/fgre_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "falling_glyph_rain_engine_macros.svh"
module fgre_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] glyph_out,
  input wire logic [7:0] glow_out,
  input wire logic [1:0] blip_mode_out
);

  `FGRE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(glyph_out) && $stable(glow_out) && $stable(blip_mode_out))
  `FGRE_ASSERT_IMP(a_init_busy, clk, rst, $past(rst), in_stall)
  `FGRE_ASSERT_NXT(a_busy_after_request, clk, rst, in_valid && !in_stall, in_stall)
  `FGRE_ASSERT_IMP(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind falling_glyph_rain_engine fgre_checker u_fgre_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .glyph_out     (glyph_out),
  .glow_out      (glow_out),
  .blip_mode_out (blip_mode_out)
);
`default_nettype wire

// ===== tb/fgre_checker.sv =====
`timescale 1ns / 1ps
module fgre_scoreboard
  import fgre_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int GLYPH_COUNT = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ACTION_W-1:0]  action,
  input  logic [6:0]           column,
  input  logic [5:0]           row,
  input  logic [WORD_W-1:0]    rand_word,
  input  logic [GLYPH_W-1:0]   rand_glyph_a,
  input  logic [GLYPH_W-1:0]   rand_glyph_b,
  input  logic [GLYPH_W-1:0]   rand_glyph_c,
  input  logic [GLYPH_W-1:0]   rand_glyph_d,
  input  logic [GLYPH_W-1:0]   rand_glyph_e,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [GLYPH_W-1:0]   glyph_out,
  input  logic [GLOW_W-1:0]    glow_out,
  input  logic [MODE_W-1:0]    blip_mode_out,
  output int                   error_count,
  output int                   pending_count,
  output int                   checked_count
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;

  typedef struct {
    logic [GLYPH_W-1:0] glyph;
    logic [GLOW_W-1:0]  glow;
    logic [MODE_W-1:0]  mode;
  } cell_result_t;

  logic [GLYPH_W-1:0] glyph_grid [CELLS];
  logic [GLOW_W-1:0]  glow_grid [CELLS];
  mode_e              col_mode [MAX_COLUMNS];
  logic [5:0]         col_row [MAX_COLUMNS];
  logic [SPEED_W-1:0] col_speed [MAX_COLUMNS];
  logic [TIMER_W-1:0] col_timer [MAX_COLUMNS];
  logic [7:0]         cols_reg;
  logic [6:0]         rows_reg;
  logic [GLYPH_W-1:0] picks [PICKS];
  cell_result_t       expected_cells [$];

  function automatic int clamp_count(int v, int max_v);
    if (v == 0) return 1;
    return (v > max_v) ? max_v : v;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_pick(int k);
    int kk;
    kk = (k > PICKS - 1) ? PICKS - 1 : k;
    return GLYPH_W'(int'(picks[kk]) % GLYPH_COUNT);
  endfunction

  task automatic wipe_grid();
    for (int i = 0; i < CELLS; i++) begin
      glyph_grid[i] = GLYPH_W'(GLYPH_COUNT - 1);
      glow_grid[i] = '0;
    end
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mode[c] = MODE_IDLE;
      col_row[c] = '0;
      col_speed[c] = '0;
      col_timer[c] = '0;
    end
  endtask

  task automatic step_column(int c, int rows, logic [31:0] w);
    int r, ix, sp, start, rr, k;
    logic [TIMER_W-1:0] t;
    logic pos;
    for (int y = 0; y < rows; y++) begin
      ix = y * MAX_COLUMNS + c;
      if (glow_grid[ix] != GLOW_STICKY) glow_grid[ix] = GLOW_W'((int'(glow_grid[ix]) * 9) / 10);
    end
    case (col_mode[c])
      MODE_IDLE: begin
        if (w[7:4] == 4'hf) begin
          col_mode[c] = MODE_DROP;
          col_row[c] = '0;
          col_speed[c] = SPEED_W'(w[31:30] + 3'd1);
          col_timer[c] = '0;
        end else if (w[15:12] == 4'hf) begin
          col_mode[c] = MODE_SLIDE;
          col_timer[c] = TIMER_W'(w[31:28]) + 8'd15;
          col_speed[c] = SPEED_W'(w[25:24]) + 3'd2;
        end
      end
      MODE_DROP: begin
        r = col_row[c];
        t = col_timer[c];
        pos = (t != 0) && (t < 128);
        k = 0;
        for (int i = col_speed[c]; i > 0; i--) begin
          if (r < rows) begin
            ix = r * MAX_COLUMNS + c;
            glow_grid[ix] = pos ? GLOW_STICKY : GLOW_W'(254 - i * 10);
            glyph_grid[ix] = glyph_pick(k);
          end
          k++;
          r++;
          if (r >= rows) break;
        end
        if (pos) t = t - 8'd1;
        if (r >= rows) begin
          col_mode[c] = MODE_IDLE;
          r = 0;
        end
        col_row[c] = 6'(r);
        if (t == 0) begin
          if (w[13:8] == 6'h3f) begin
            t = TIMER_W'(w[31:28]) + 8'd8;
          end else if (col_speed[c] > 1 && w[6:0] == 7'h7f) begin
            col_mode[c] = MODE_HOLD;
            t = TIMER_W'(w[31:26]) + 8'd30;
          end
        end
        col_timer[c] = t;
      end
      MODE_HOLD: begin
        r = col_row[c];
        if (r < rows) begin
          ix = r * MAX_COLUMNS + c;
          glow_grid[ix] = GLOW_BRIGHT;
          glyph_grid[ix] = glyph_pick(0);
        end
        col_timer[c] = col_timer[c] - 8'd1;
        if (col_timer[c] >= 128) col_mode[c] = MODE_DROP;
      end
      default: begin
        sp = col_speed[c];
        col_timer[c] = col_timer[c] - 8'd1;
        if (col_timer[c] >= 128) col_mode[c] = MODE_IDLE;
        for (int y = rows - 1; y >= sp; y--)
          glyph_grid[y * MAX_COLUMNS + c] = glyph_grid[(y - sp) * MAX_COLUMNS + c];
        start = (rows > sp) ? sp - 1 : rows - 1;
        for (int j = 0; j < sp; j++) begin
          rr = start - j;
          if (rr >= 0 && rr < rows) glyph_grid[rr * MAX_COLUMNS + c] = glyph_pick(j);
        end
      end
    endcase
  endtask

  task automatic predict_request();
    cell_result_t res;
    int cols, rows, ix;
    cols = clamp_count(cols_reg, MAX_COLUMNS);
    rows = clamp_count(rows_reg, MAX_ROWS);
    res = '{glyph: '0, glow: '0, mode: '0};
    picks[0] = rand_glyph_a;
    picks[1] = rand_glyph_b;
    picks[2] = rand_glyph_c;
    picks[3] = rand_glyph_d;
    picks[4] = rand_glyph_e;
    case (action)
      ACT_UPDATE: begin
        if (column < cols) begin
          step_column(column, rows, rand_word);
          res.mode = col_mode[column];
        end
      end
      ACT_READ: begin
        if (column < cols && row < rows) begin
          ix = row * MAX_COLUMNS + column;
          res.glyph = glyph_grid[ix];
          res.glow = glow_grid[ix];
          res.mode = col_mode[column];
        end
      end
      ACT_CLEAR: wipe_grid();
      default: ;
    endcase
    expected_cells.push_back(res);
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      wipe_grid();
      cols_reg = 8'(COLUMNS_RST);
      rows_reg = 7'(ROWS_RST);
      expected_cells.delete();
      error_count = 0;
      checked_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result with no request pending: glyph %0d glow %0d mode %0d",
                   $time, glyph_out, glow_out, blip_mode_out);
          error_count++;
        end else begin
          want = expected_cells.pop_front();
          checked_count++;
          if (glyph_out !== want.glyph) begin
            $display("%0t: glyph expected %0d actual %0d", $time, want.glyph, glyph_out);
            error_count++;
          end
          if (glow_out !== want.glow) begin
            $display("%0t: glow expected %0d actual %0d", $time, want.glow, glow_out);
            error_count++;
          end
          if (blip_mode_out !== want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, blip_mode_out);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_COLUMNS) cols_reg = cfg_data;
        else rows_reg = cfg_data[6:0];
      end
      if (in_valid && !in_stall) predict_request();
    end
    pending_count = expected_cells.size();
  end

endmodule

// ===== tb/tb_falling_glyph_rain_engine.sv =====
`timescale 1ns / 1ps
module tb_falling_glyph_rain_engine;
  import fgre_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACTION_W-1:0]  action;
  logic [6:0]           column;
  logic [5:0]           row;
  logic [WORD_W-1:0]    rand_word;
  logic [GLYPH_W-1:0]   rand_glyph_a, rand_glyph_b, rand_glyph_c, rand_glyph_d, rand_glyph_e;
  logic                 out_valid;
  logic                 out_stall;
  logic [GLYPH_W-1:0]   glyph_out;
  logic [GLOW_W-1:0]    glow_out;
  logic [MODE_W-1:0]    blip_mode_out;
  int                   error_count, pending_count, checked_count;
  logic                 calm;
  int                   n_update, n_read, n_clear, cols_now;

  falling_glyph_rain_engine dut (.*);

  fgre_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  // result side backpressure
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    while (!calm) begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic write_reg(cfg_reg_e idx, int value);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 8'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_COLUMNS) cols_now = (value == 0) ? 1 : (value > 128 ? 128 : value);
  endtask

  task automatic send_request(logic [1:0] act, int col, int rw, logic [31:0] w,
                              logic [34:0] glyphs);
    action = act;
    column = 7'(col);
    row = 6'(rw);
    rand_word = w;
    {rand_glyph_a, rand_glyph_b, rand_glyph_c, rand_glyph_d, rand_glyph_e} = glyphs;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    case (act)
      ACT_UPDATE: n_update++;
      ACT_READ: n_read++;
      ACT_CLEAR: n_clear++;
      default: ;
    endcase
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  function automatic logic [34:0] some_glyphs();
    logic [34:0] g;
    for (int i = 0; i < 5; i++)
      g[i*7 +: 7] = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(80, 127))
                                                  : 7'($urandom_range(0, 79));
    return g;
  endfunction

  // word biased so that falls, slides, stops and timer reloads all happen
  function automatic logic [31:0] blip_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[7:4] = 4'hf;
      1: begin w[7:4] = 4'h0; w[15:12] = 4'hf; end
      2: w[13:8] = 6'h3f;
      3: begin w[13:8] = 6'h00; w[6:0] = 7'h7f; end
      4: w[6:0] = 7'h7f;
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_phase(int count);
    int hot, c;
    hot = $urandom_range(0, cols_now - 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) hot = $urandom_range(0, cols_now - 1);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : hot;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
          send_request(ACT_UPDATE, c, $urandom_range(0, 63), blip_word(), some_glyphs());
        11, 12, 13, 14, 15, 16, 17:
          send_request(ACT_READ, c, $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                       : $urandom_range(0, 7), $urandom, some_glyphs());
        18: send_request(ACT_UNUSED, $urandom_range(0, 127), $urandom_range(0, 63), $urandom,
                         35'($urandom));
        default:
          if ($urandom_range(0, 5) == 0)
            send_request(ACT_CLEAR, c, 0, $urandom, some_glyphs());
          else
            send_request(ACT_READ, c, $urandom_range(0, 63), $urandom, some_glyphs());
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_UPDATE;
    column = '0;
    row = '0;
    rand_word = '0;
    {rand_glyph_a, rand_glyph_b, rand_glyph_c, rand_glyph_d, rand_glyph_e} = '0;
    n_update = 0;
    n_read = 0;
    n_clear = 0;
    cols_now = COLUMNS_RST;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    while (in_stall) @(negedge clk);

    // directed: reset defaults, fall, stop, slide, out of range cases
    send_request(ACT_READ, 0, 0, 0, '0);
    send_request(ACT_READ, 79, 59, 32'hffff_ffff, '1);
    send_request(ACT_READ, 80, 0, 0, '0);
    send_request(ACT_READ, 0, 60, 0, '0);
    send_request(ACT_UPDATE, 3, 0, 32'hc000_00f0, {7'd0, 7'd79, 7'd80, 7'd127, 7'd5});
    for (int i = 0; i < 4; i++)
      send_request(ACT_UPDATE, 3, 0, 32'hfc00_3f7f, {7'd1, 7'd2, 7'd3, 7'd4, 7'd127});
    send_request(ACT_READ, 3, 1, 0, '0);
    send_request(ACT_UPDATE, 5, 0, 32'hf300_f000, {7'd10, 7'd20, 7'd30, 7'd40, 7'd127});
    send_request(ACT_UPDATE, 5, 0, 0, {7'd11, 7'd21, 7'd31, 7'd41, 7'd51});
    send_request(ACT_READ, 5, 0, 0, '0);
    send_request(ACT_UPDATE, 7, 0, 32'h4000_00f0, some_glyphs());
    send_request(ACT_UPDATE, 7, 0, 32'hffff_ff7f, some_glyphs());
    send_request(ACT_UPDATE, 7, 0, 32'h0000_007f, some_glyphs());
    send_request(ACT_UPDATE, 127, 0, 32'h0000_00f0, some_glyphs());
    send_request(ACT_UNUSED, 0, 0, 0, '0);
    send_request(ACT_CLEAR, 0, 0, 0, '0);
    send_request(ACT_READ, 3, 1, 0, '0);

    random_phase(120);
    write_reg(REG_COLUMNS, 128);
    write_reg(REG_ROWS, 64);
    random_phase(110);
    write_reg(REG_COLUMNS, 1);
    write_reg(REG_ROWS, 1);
    random_phase(60);
    write_reg(REG_COLUMNS, 0);
    write_reg(REG_ROWS, 0);
    random_phase(50);
    write_reg(REG_COLUMNS, 255);
    write_reg(REG_ROWS, 127);
    random_phase(100);
    write_reg(REG_COLUMNS, 6);
    write_reg(REG_ROWS, 3);
    random_phase(90);
    write_reg(REG_COLUMNS, 9);
    write_reg(REG_ROWS, 8);
    calm = 1'b1;
    random_phase(110);
    in_valid = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d updates, %0d reads, %0d clears over seven column and row settings",
             n_update, n_read, n_clear);
    $display("%0d results checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
